>>> design/ism_pkg.sv
`timescale 1ns / 1ps

package ism_pkg;

	// Request codes carried by req_type; the unused code behaves as a read.
	localparam logic [1:0] REQ_UPDATE = 2'd0;
	localparam logic [1:0] REQ_READ   = 2'd1;
	localparam logic [1:0] REQ_WRITE  = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_DE4 = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PROB_DE8 = 1'b1;

	localparam int unsigned SITE_W = 12;
	localparam int unsigned PROB_W = 32;
	localparam int unsigned DE_W   = 5;

	localparam logic signed [DE_W-1:0] DE_PLUS4 = 5'sd4;
	localparam logic [DE_W-1:0]        DE_BIAS  = 5'd8;

	typedef logic signed [DE_W-1:0] de_t;

	// Which site the shared address unit points at.
	typedef enum logic [2:0] {
		NB_C,
		NB_W,
		NB_E,
		NB_N,
		NB_S
	} nbr_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LAST,
		ST_DECIDE
	} state_t;

	// Outcome of one item, handed from the decision logic to the sequencer.
	typedef struct packed {
		logic we;
		logic wdata;
		logic spin;
		logic flip;
		de_t  de;
	} dec_t;

endpackage

>>> design/ism_req_if.sv
`timescale 1ns / 1ps

interface ism_req_if;
	import ism_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [SITE_W-1:0]   site_index;
	logic [PROB_W-1:0]   accept_draw;
	logic                spin_in;

	modport source (
		output valid, req_type, site_index, accept_draw, spin_in,
		input  ready
	);

	modport sink (
		input  valid, req_type, site_index, accept_draw, spin_in,
		output ready
	);

endinterface

>>> design/ism_rsp_if.sv
`timescale 1ns / 1ps

interface ism_rsp_if;
	import ism_pkg::*;

	logic valid;
	logic ready;
	logic spin_out;
	logic flipped;
	de_t  energy_step;

	modport source (
		output valid, spin_out, flipped, energy_step,
		input  ready
	);

	modport sink (
		input  valid, spin_out, flipped, energy_step,
		output ready
	);

endinterface

>>> design/ising_metropolis_site_update.sv
`timescale 1ns / 1ps

// Metropolis site update for a SIDE x SIDE periodic Ising lattice of one-bit spins, held in a
// single synchronous RAM in Z-order. After reset the block first sweeps the RAM to +1, one
// site per cycle, and takes no request word until that sweep is done; configuration writes
// are accepted throughout. Each request word is one of: update (read the site and its four
// neighbours, flip by the Metropolis rule), read, or write. Every request gives exactly one
// response word. The single RAM read port sets the pace: an update issues five reads one
// after another and then decides and writes back before the next request is accepted; a
// read or write needs only the center site. The response sits in an output register, so a
// new request is already being processed while the previous response waits; only the final
// write-back waits for that register. The acceptance fractions for dE = 4 and dE = 8 are
// compared strictly against the draw, so a fraction of zero never accepts.
module ising_metropolis_site_update #(
	parameter int unsigned SIDE = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ism_req_if.sink                       req,
	ism_rsp_if.source                     rsp,
	input  logic                          cfg_we,
	input  logic [ism_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ism_pkg::PROB_W-1:0]    cfg_wdata
);
	import ism_pkg::*;

	localparam int unsigned LB    = $clog2(SIDE);
	localparam int unsigned AW    = 2 * LB;
	localparam int unsigned DEPTH = SIDE * SIDE;

	state_t state_q, state_d;

	logic [AW-1:0]     clr_q;
	nbr_t              step_q;
	nbr_t              data_step_q;
	logic              data_vld_q;
	logic [1:0]        req_type_q;
	logic [LB-1:0]     x_q;
	logic [LB-1:0]     y_q;
	logic [PROB_W-1:0] draw_q;
	logic              spin_in_q;
	logic              spin_c_q;
	logic [2:0]        ones_q;
	logic [PROB_W-1:0] prob_de4_q;
	logic [PROB_W-1:0] prob_de8_q;

	logic              out_vld_q;
	logic              out_spin_q;
	logic              out_flip_q;
	de_t               out_de_q;

	logic [SITE_W+AW-1:0] idx_wide;
	nbr_t                 step_sel;
	logic [AW-1:0]        nb_addr;
	logic [AW-1:0]        ram_addr;
	logic                 ram_we;
	logic                 ram_wdata;
	logic                 ram_rdata;
	logic                 req_ready;
	logic                 commit;
	logic                 last_step;
	dec_t                 dec;

	// Index beyond the lattice wraps: only the low 2*log2(SIDE) bits count.
	assign idx_wide = (SITE_W + AW)'(req.site_index);

	// An update walks all five sites; read and write stop after the center.
	assign last_step = (step_q == NB_S) || (req_type_q != REQ_UPDATE);

	ism_addr #(
		.LB (LB)
	) u_addr (
		.x    (x_q),
		.y    (y_q),
		.step (step_sel),
		.addr (nb_addr)
	);

	ism_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_lattice (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	ism_decide u_decide (
		.req_type (req_type_q),
		.spin_c   (spin_c_q),
		.ones     (ones_q),
		.draw     (draw_q),
		.prob_de4 (prob_de4_q),
		.prob_de8 (prob_de8_q),
		.spin_in  (spin_in_q),
		.dec      (dec)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (last_step) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!out_vld_q || rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		req_ready = 1'b0;
		commit    = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = 1'b1;
		ram_addr  = nb_addr;
		step_sel  = NB_C;
		case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_IDLE: begin
				req_ready = 1'b1;
			end
			ST_READ: begin
				step_sel = step_q;
			end
			ST_DECIDE: begin
				commit    = !out_vld_q || rsp.ready;
				ram_we    = commit && dec.we;
				ram_wdata = dec.wdata;
			end
			default: begin
				step_sel = NB_C;
			end
		endcase
	end

	assign req.ready       = req_ready;
	assign rsp.valid       = out_vld_q;
	assign rsp.spin_out    = out_spin_q;
	assign rsp.flipped     = out_flip_q;
	assign rsp.energy_step = out_de_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			step_q     <= NB_C;
			data_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
			prob_de4_q <= '0;
			prob_de8_q <= '0;
		end else begin
			state_q    <= state_d;
			data_vld_q <= (state_q == ST_READ);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (req_ready && req.valid) begin
				step_q <= NB_C;
			end else if (state_q == ST_READ && !last_step) begin
				step_q <= nbr_t'(step_q + 3'd1);
			end
			if (commit) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PROB_DE4: prob_de4_q <= cfg_wdata;
					REG_PROB_DE8: prob_de8_q <= cfg_wdata;
					default:      prob_de4_q <= prob_de4_q;
				endcase
			end
		end
	end

	// Request payload and the gathered spins need no reset.
	always_ff @(posedge clk) begin
		data_step_q <= step_q;
		if (req_ready && req.valid) begin
			req_type_q <= req.req_type;
			x_q        <= idx_wide[LB-1:0];
			y_q        <= idx_wide[AW-1:LB];
			draw_q     <= req.accept_draw;
			spin_in_q  <= req.spin_in;
			ones_q     <= '0;
		end else if (data_vld_q) begin
			if (data_step_q == NB_C) begin
				spin_c_q <= ram_rdata;
			end else begin
				ones_q <= ones_q + {2'b00, ram_rdata};
			end
		end
		if (commit) begin
			out_spin_q <= dec.spin;
			out_flip_q <= dec.flip;
			out_de_q   <= dec.de;
		end
	end

`ifndef NO_ASSERTIONS
	// No request may be taken while the lattice is still being cleared.
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !req.ready)
		else $error("request accepted during lattice clear");

	// The lattice is written only by the clear sweep or by the final decision.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_DECIDE))
		else $error("lattice written outside clear or decide");

	// A fresh response appears only right after a decision.
	a_rsp_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_DECIDE)
		else $error("response raised without a decision");

	// An accepted request always starts with the center read.
	a_start_center: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_READ && step_q == NB_C))
		else $error("accepted request did not start at the center site");
`endif

endmodule

>>> design/ism_ram.sv
`timescale 1ns / 1ps

module ism_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/ism_addr.sv
`timescale 1ns / 1ps

module ism_addr #(
	parameter int unsigned LB = 6
) (
	input  logic [LB-1:0]   x,
	input  logic [LB-1:0]   y,
	input  ism_pkg::nbr_t   step,
	output logic [2*LB-1:0] addr
);
	import ism_pkg::*;

	logic [LB-1:0] xs;
	logic [LB-1:0] ys;

	// Coordinates wrap at the lattice edge by plain modular arithmetic.
	always_comb begin
		xs = x;
		ys = y;
		case (step)
			NB_W:    xs = x - LB'(1);
			NB_E:    xs = x + LB'(1);
			NB_N:    ys = y - LB'(1);
			NB_S:    ys = y + LB'(1);
			default: begin
				xs = x;
				ys = y;
			end
		endcase
	end

	// Z-order interleave: x on even address bits, y on odd ones.
	always_comb begin
		for (int i = 0; i < LB; i++) begin
			addr[2*i]   = xs[i];
			addr[2*i+1] = ys[i];
		end
	end

endmodule

>>> design/ism_decide.sv
`timescale 1ns / 1ps

module ism_decide (
	input  logic [1:0]                 req_type,
	input  logic                       spin_c,
	input  logic [2:0]                 ones,
	input  logic [ism_pkg::PROB_W-1:0] draw,
	input  logic [ism_pkg::PROB_W-1:0] prob_de4,
	input  logic [ism_pkg::PROB_W-1:0] prob_de8,
	input  logic                       spin_in,
	output ism_pkg::dec_t              dec
);
	import ism_pkg::*;

	logic [DE_W-1:0] de_up;
	de_t             de;
	logic            flip;

	// With n neighbours at +1 the field sum is 2n-4, so dE = s*(4n-8).
	always_comb begin
		de_up = {ones, 2'b00} - DE_BIAS;
		de    = spin_c ? $signed(de_up) : $signed(DE_W'(0) - de_up);
		if (de[DE_W-1] || de == '0) begin
			flip = 1'b1;
		end else if (de == DE_PLUS4) begin
			flip = draw < prob_de4;
		end else begin
			flip = draw < prob_de8;
		end
	end

	always_comb begin
		dec = '0;
		case (req_type)
			REQ_UPDATE: begin
				dec.we    = flip;
				dec.wdata = ~spin_c;
				dec.spin  = spin_c ^ flip;
				dec.flip  = flip;
				dec.de    = de;
			end
			REQ_WRITE: begin
				dec.we    = 1'b1;
				dec.wdata = spin_in;
				dec.spin  = spin_in;
			end
			default: begin
				dec.spin = spin_c;
			end
		endcase
	end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

// Checks the Metropolis site update block against its own model of the spin lattice.
// Requests go in through a queue that the main initial block fills phase by phase. A
// negedge driver takes words off that queue and a posedge monitor does two things: it
// predicts the response of every request word at the edge that accepts it, and it
// compares every response word with the oldest prediction. Between phases the stimulus
// drains completely before the acceptance fractions are rewritten, so the model and the
// block always see the same configuration.
module testbench;
	import ism_pkg::*;

	localparam int SIDE        = 64;
	localparam int SITES       = SIDE * SIDE;
	localparam int STALL_LIMIT = 20000;
	localparam int MAX_REPORTS = 10;
	localparam int IDLE_PCT    = 23;

	// The fourth request code has no name in the package; the block treats it as a read.
	localparam logic [1:0]        REQ_SPARE = 2'd3;
	localparam logic [PROB_W-1:0] PROB_ALL  = '1;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SITE_W-1:0] site;
		logic [PROB_W-1:0] draw;
		logic              spin;
	} site_req_t;

	typedef struct packed {
		logic spin;
		logic flipped;
		de_t  de;
	} site_rsp_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PROB_W-1:0]    cfg_wdata;

	ism_req_if req_ch();
	ism_rsp_if rsp_ch();

	ising_metropolis_site_update #(
		.SIDE(SIDE)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// The model keeps the lattice in row-major order. The block stores it in Z-order, but
	// that is only a permutation of addresses and cannot be seen from the ports.
	logic              spin_grid [SITES];
	logic [PROB_W-1:0] prob_de4;
	logic [PROB_W-1:0] prob_de8;

	site_req_t pending_requests[$];
	site_rsp_t expected_outcomes[$];

	logic req_taken    = 1'b0;
	logic steady_flow  = 1'b0;
	int   error_count  = 0;
	int   idle_cycles  = 0;

	always #4 clk = ~clk;

	// Spin of a site as +1 or -1, with both coordinates wrapped around the torus.
	function automatic int lattice_spin(int x, int y);
		return spin_grid[((y + SIDE) % SIDE) * SIDE + (x + SIDE) % SIDE] ? 1 : -1;
	endfunction

	// Applies one request word to the model lattice and returns the response it must give.
	function automatic site_rsp_t apply_site_request(site_req_t r);
		int        idx;
		int        x;
		int        y;
		int        s;
		int        sum;
		int        de;
		logic      flip;
		site_rsp_t res;
		idx  = int'(r.site) % SITES;
		x    = idx % SIDE;
		y    = idx / SIDE;
		de   = 0;
		flip = 1'b0;
		if (r.kind == REQ_UPDATE) begin
			s   = spin_grid[idx] ? 1 : -1;
			sum = lattice_spin(x - 1, y) + lattice_spin(x + 1, y) +
			      lattice_spin(x, y - 1) + lattice_spin(x, y + 1);
			de  = 2 * s * sum;
			// A flip that lowers or keeps the energy always goes through. Otherwise the
			// draw must lie strictly below the fraction that belongs to this energy step.
			if (de <= 0) begin
				flip = 1'b1;
			end else if (de == 4) begin
				flip = r.draw < prob_de4;
			end else begin
				flip = r.draw < prob_de8;
			end
			if (flip) begin
				spin_grid[idx] = ~spin_grid[idx];
			end
		end else if (r.kind == REQ_WRITE) begin
			spin_grid[idx] = r.spin;
		end
		res.spin    = spin_grid[idx];
		res.flipped = flip;
		res.de      = de_t'(de);
		return res;
	endfunction

	// Driver. A new word goes out only once the previous one was taken, so valid never
	// drops while a word is waiting. Gaps between words and stalls on the response side
	// are both drawn per cycle, except while steady_flow asks for a clean stream.
	always @(negedge clk) begin : driver
		site_req_t next_req;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (pending_requests.size() != 0 &&
			    (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = pending_requests.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.req_type    <= next_req.kind;
				req_ch.site_index  <= next_req.site;
				req_ch.accept_draw <= next_req.draw;
				req_ch.spin_in     <= next_req.spin;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
		rsp_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
	end

	// Monitor. The response is checked before the newly accepted request is predicted, so a
	// response that arrives with nothing outstanding is never matched against that request.
	always @(posedge clk) begin : monitor
		site_rsp_t want;
		site_req_t arrived;
		req_taken <= arst_n && req_ch.valid && req_ch.ready;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_outcomes.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS) begin
					$display("response word with none outstanding: spin %0d flipped %0d dE %0d",
					         rsp_ch.spin_out, rsp_ch.flipped, rsp_ch.energy_step);
				end
			end else begin
				want = expected_outcomes.pop_front();
				if (rsp_ch.spin_out !== want.spin || rsp_ch.flipped !== want.flipped ||
				    rsp_ch.energy_step !== want.de) begin
					error_count++;
					if (error_count <= MAX_REPORTS) begin
						$display("mismatch: expected spin %0d flipped %0d dE %0d, got %0d %0d %0d",
						         want.spin, want.flipped, want.de, rsp_ch.spin_out,
						         rsp_ch.flipped, rsp_ch.energy_step);
					end
				end
			end
		end
		if (arst_n && req_ch.valid && req_ch.ready) begin
			arrived = '{req_ch.req_type, req_ch.site_index, req_ch.accept_draw, req_ch.spin_in};
			expected_outcomes.push_back(apply_site_request(arrived));
		end
	end

	// Watchdog. The clearing sweep after reset keeps the request side closed while it visits
	// every site, so the limit sits well above the length of that sweep.
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic queue_request(logic [1:0] kind, logic [SITE_W-1:0] site,
	                             logic [PROB_W-1:0] draw, logic spin);
		pending_requests.push_back('{kind, site, draw, spin});
	endtask

	// Blocks until every queued word was taken and every response has come back.
	task automatic wait_until_drained();
		do begin
			@(negedge clk);
		end while (pending_requests.size() != 0 || req_ch.valid ||
		           expected_outcomes.size() != 0);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [PROB_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (index == REG_PROB_DE4) begin
			prob_de4 = value;
		end else begin
			prob_de8 = value;
		end
	endtask

	// New acceptance fractions for the next phase. The short pause leaves the block idle
	// for a while between phases.
	task automatic configure(logic [PROB_W-1:0] p4, logic [PROB_W-1:0] p8);
		wait_until_drained();
		repeat (16) @(posedge clk);
		write_register(REG_PROB_DE4, p4);
		write_register(REG_PROB_DE8, p8);
	endtask

	// Random requests. Most land in two small clusters, one straddling both wrap edges and
	// one in the middle, so that writes and flips keep changing the neighborhoods of later
	// updates. Draws often sit right at one of the fractions to hit the strict comparison.
	task automatic queue_random_requests(int count);
		int                roll;
		int                x;
		int                y;
		logic [1:0]        kind;
		logic [SITE_W-1:0] site;
		logic [PROB_W-1:0] draw;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				kind = REQ_UPDATE;
			end else if (roll < 75) begin
				kind = REQ_WRITE;
			end else if (roll < 93) begin
				kind = REQ_READ;
			end else begin
				kind = REQ_SPARE;
			end
			roll = $urandom_range(9);
			if (roll < 4) begin
				x    = (SIDE - 2 + $urandom_range(3)) % SIDE;
				y    = (SIDE - 2 + $urandom_range(3)) % SIDE;
				site = SITE_W'(y * SIDE + x);
			end else if (roll < 6) begin
				x    = SIDE / 2 - 1 + $urandom_range(3);
				y    = SIDE / 3 + $urandom_range(3);
				site = SITE_W'(y * SIDE + x);
			end else begin
				site = SITE_W'($urandom_range(SITES - 1));
			end
			roll = $urandom_range(9);
			case (roll)
				0: draw = '0;
				1: draw = PROB_ALL;
				2: draw = prob_de4 + $urandom_range(2) - 1;
				3: draw = prob_de8 + $urandom_range(2) - 1;
				default: draw = $urandom;
			endcase
			queue_request(kind, site, draw, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		cfg_we             = 1'b0;
		cfg_index          = REG_PROB_DE4;
		cfg_wdata          = '0;
		arst_n             = 1'b0;
		prob_de4           = '0;
		prob_de8           = '0;
		for (int i = 0; i < SITES; i++) begin
			spin_grid[i] = 1'b1;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Both fractions at zero: no uphill flip may ever be accepted. The words below build
		// neighborhoods around sites 0, 100 and 200 that give every energy step, including the wraps to
		// x = 63 and y = 63, and cover reads through the spare request code.
		configure('0, '0);
		queue_request(REQ_READ,   12'd0,    '0,       1'b0);
		queue_request(REQ_READ,   12'd4095, PROB_ALL, 1'b1);
		queue_request(REQ_SPARE,  12'hAAA,  '0,       1'b1);
		queue_request(REQ_UPDATE, 12'd0,    '0,       1'b0);
		queue_request(REQ_WRITE,  12'd1,    PROB_ALL, 1'b0);
		queue_request(REQ_WRITE,  12'd4032, '0,       1'b0);
		queue_request(REQ_UPDATE, 12'd0,    $urandom, 1'b1);
		queue_request(REQ_UPDATE, 12'd0,    $urandom, 1'b0);
		queue_request(REQ_WRITE,  12'd63,   '0,       1'b0);
		queue_request(REQ_WRITE,  12'd64,   '0,       1'b0);
		queue_request(REQ_UPDATE, 12'd0,    PROB_ALL, 1'b1);
		queue_request(REQ_UPDATE, 12'd0,    '0,       1'b0);
		queue_request(REQ_WRITE,  12'd101,  '0,       1'b0);
		queue_request(REQ_UPDATE, 12'd100,  '0,       1'b1);
		queue_request(REQ_WRITE,  12'd200,  '0,       1'b0);
		queue_request(REQ_WRITE,  12'd201,  '0,       1'b0);
		queue_request(REQ_UPDATE, 12'd200,  $urandom, 1'b0);
		queue_request(REQ_WRITE,  12'd4095, PROB_ALL, 1'b1);
		queue_request(REQ_READ,   12'd4095, '0,       1'b0);
		queue_request(REQ_WRITE,  12'h555,  $urandom, 1'b0);
		queue_request(REQ_SPARE,  12'h555,  PROB_ALL, 1'b0);

		// Both fractions saturated: every draw except all ones is accepted.
		configure(PROB_ALL, PROB_ALL);
		queue_request(REQ_UPDATE, 12'd100,  PROB_ALL,      1'b0);
		queue_request(REQ_UPDATE, 12'd100,  PROB_ALL - 1,  1'b0);
		queue_request(REQ_UPDATE, 12'd2048, PROB_ALL,      1'b1);
		queue_request(REQ_UPDATE, 12'd2048, PROB_ALL - 1,  1'b1);
		queue_random_requests(200);

		// A clean stream with no gaps and no stalls on either side.
		configure(32'h8000_0000, 32'h0000_0001);
		steady_flow = 1'b1;
		queue_random_requests(300);
		wait_until_drained();
		steady_flow = 1'b0;

		configure(32'h0000_0001, PROB_ALL);
		queue_random_requests(250);

		configure($urandom, $urandom);
		queue_random_requests(475);

		wait_until_drained();
		repeat (32) @(posedge clk);
		if (error_count == 0 && expected_outcomes.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> files.f
design/ism_pkg.sv
design/ism_req_if.sv
design/ism_rsp_if.sv
design/ism_ram.sv
design/ism_addr.sv
design/ism_decide.sv
design/ising_metropolis_site_update.sv
tb/testbench.sv
